// ===== rtl/v3ou_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3ou_pkg
// Shared types and constants of the Q16.16 3D vector unit: request and
// result beats, operation classes, sequencer states and the CORDIC tables.
// ----------------------------------------------------------------------------
package v3ou_pkg;

    // default CORDIC iteration count
    localparam int CORDIC_STEPS_DEF = 16;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // angle constants, degrees in Q16.16
    localparam logic [31:0] DEG360 = 32'd23592960;
    localparam logic signed [32:0] DEG360_S = 33'sd23592960;
    localparam logic signed [32:0] DEG180_S = 33'sd11796480;
    localparam logic signed [32:0] DEG90_S  = 33'sd5898240;

    // degrees to Q2.30 radians: round(pi/180 * 2^40), split in two pieces
    localparam logic [34:0] DEG_TO_RAD = 35'd19190098069;
    localparam int          RAD_SPLIT  = 18;
    localparam logic [17:0] RAD_LO     = DEG_TO_RAD[17:0];
    localparam logic [16:0] RAD_HI     = DEG_TO_RAD[34:18];

    // CORDIC start gain, Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // arctan(2^-i), Q2.30
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // operation selector codes
    typedef enum logic [3:0] {
        REQ_ADD   = 4'd0,
        REQ_SUB   = 4'd1,
        REQ_NEG   = 4'd2,
        REQ_SCALE = 4'd3,
        REQ_DOT   = 4'd4,
        REQ_CROSS = 4'd5,
        REQ_LEN   = 4'd6,
        REQ_NORM  = 4'd7,
        REQ_ROTX  = 4'd8,
        REQ_ROTY  = 4'd9,
        REQ_ROTZ  = 4'd10
    } t_req;

    // execution class chosen by the front end
    typedef enum logic [2:0] {
        CL_NONE,
        CL_LIN,
        CL_MUL,
        CL_SQRT,
        CL_ROT
    } t_cls;

    // back end sequencer states
    typedef enum logic [3:0] {
        BE_IDLE,
        BE_EXEC,
        BE_MUL,
        BE_SQRT,
        BE_SQFIN,
        BE_DSET,
        BE_DIV,
        BE_RED,
        BE_RAD0,
        BE_RAD1,
        BE_CORD,
        BE_OUT
    } t_be_state;

    // request beat
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_comp;
        logic signed [31:0] bz;
        logic signed [31:0] scalar_in;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_out;
        logic               zero_length;
    } t_out_beat;

    // queued command: class plus request
    typedef struct packed {
        t_cls     cls;
        t_in_beat req;
    } t_q_beat;

    // queue handshake toward the back end
    typedef struct packed {
        logic    valid;
        t_q_beat item;
    } t_q_head;

endpackage

// ===== rtl/v3ou_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3ou_front
// Accepts commands, classifies them by operation and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module v3ou_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  v3ou_pkg::t_in_beat i_req,
    input  logic               i_pop,
    output v3ou_pkg::t_q_head  o_head
);
    import v3ou_pkg::*;

    t_q_beat          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, n_wr;
    logic [QAW-1:0]   r_rd, n_rd;
    logic [QAW:0]     r_count, n_count;
    logic             w_push;
    t_cls             w_cls;

    // classify the incoming beat
    always_comb begin
        unique case (i_req.req_type) inside
            REQ_ADD, REQ_SUB, REQ_NEG:           w_cls = CL_LIN;
            REQ_SCALE, REQ_DOT, REQ_CROSS:       w_cls = CL_MUL;
            REQ_LEN, REQ_NORM:                   w_cls = CL_SQRT;
            REQ_ROTX, REQ_ROTY, REQ_ROTZ:        w_cls = CL_ROT;
            default:                             w_cls = CL_NONE;
        endcase
    end

    assign o_busy = (r_count == (QAW+1)'(QDEPTH));
    assign w_push = i_start && !o_busy;

    // pointers and fill level
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= '{cls: w_cls, req: i_req};
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    // fill level moves by one beat at most
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1))
        else $error("queue count jumped");

    // back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop on empty queue");

endmodule

// ===== rtl/v3ou_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3ou_back
// Execution sequencer: shared 34x34 multiplier with accumulator, bitwise
// square root, restoring divider, angle reduction and CORDIC sine/cosine.
// ----------------------------------------------------------------------------
module v3ou_back #(
    parameter int CORDIC_STEPS = v3ou_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  v3ou_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    output v3ou_pkg::t_out_beat o_res
);
    import v3ou_pkg::*;

    // multiplier operand selects
    typedef enum logic [3:0] {
        OPS_AX, OPS_AY, OPS_AZ, OPS_BX, OPS_BY, OPS_BZ, OPS_K, OPS_C, OPS_S
    } t_opnd;

    typedef struct packed {
        t_opnd      sa;
        t_opnd      sb;
        logic       neg;
        logic       last;
        logic [1:0] dst;
    } t_pdesc;

    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;
    localparam logic signed [67:0] HALF16 = 68'sd32768;
    localparam logic signed [67:0] HALF30 = 68'sd536870912;

    function automatic t_pdesc f_pd(input t_opnd sa, input t_opnd sb, input logic neg,
                                    input logic last, input logic [1:0] dst);
        t_pdesc d;
        d.sa = sa; d.sb = sb; d.neg = neg; d.last = last; d.dst = dst;
        return d;
    endfunction

    // product program of each operation
    function automatic t_pdesc f_pdesc(input t_req req, input logic [2:0] n);
        t_pdesc d;
        d = f_pd(OPS_AX, OPS_AX, 1'b0, 1'b0, 2'd0);
        unique case (req)
            REQ_SCALE: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AX, OPS_K, 1'b0, 1'b1, 2'd0);
                    3'd1:    d = f_pd(OPS_AY, OPS_K, 1'b0, 1'b1, 2'd1);
                    default: d = f_pd(OPS_AZ, OPS_K, 1'b0, 1'b1, 2'd2);
                endcase
            end
            REQ_DOT: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AX, OPS_BX, 1'b0, 1'b0, 2'd3);
                    3'd1:    d = f_pd(OPS_AY, OPS_BY, 1'b0, 1'b0, 2'd3);
                    default: d = f_pd(OPS_AZ, OPS_BZ, 1'b0, 1'b1, 2'd3);
                endcase
            end
            REQ_CROSS: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AY, OPS_BZ, 1'b0, 1'b0, 2'd0);
                    3'd1:    d = f_pd(OPS_AZ, OPS_BY, 1'b1, 1'b1, 2'd0);
                    3'd2:    d = f_pd(OPS_AZ, OPS_BX, 1'b0, 1'b0, 2'd1);
                    3'd3:    d = f_pd(OPS_AX, OPS_BZ, 1'b1, 1'b1, 2'd1);
                    3'd4:    d = f_pd(OPS_AX, OPS_BY, 1'b0, 1'b0, 2'd2);
                    default: d = f_pd(OPS_AY, OPS_BX, 1'b1, 1'b1, 2'd2);
                endcase
            end
            REQ_LEN, REQ_NORM: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AX, OPS_AX, 1'b0, 1'b0, 2'd0);
                    3'd1:    d = f_pd(OPS_AY, OPS_AY, 1'b0, 1'b0, 2'd0);
                    default: d = f_pd(OPS_AZ, OPS_AZ, 1'b0, 1'b0, 2'd0);
                endcase
            end
            REQ_ROTX: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AY, OPS_C, 1'b0, 1'b0, 2'd1);
                    3'd1:    d = f_pd(OPS_AZ, OPS_S, 1'b1, 1'b1, 2'd1);
                    3'd2:    d = f_pd(OPS_AY, OPS_S, 1'b0, 1'b0, 2'd2);
                    default: d = f_pd(OPS_AZ, OPS_C, 1'b0, 1'b1, 2'd2);
                endcase
            end
            REQ_ROTY: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AX, OPS_C, 1'b0, 1'b0, 2'd0);
                    3'd1:    d = f_pd(OPS_AZ, OPS_S, 1'b0, 1'b1, 2'd0);
                    3'd2:    d = f_pd(OPS_AX, OPS_S, 1'b1, 1'b0, 2'd2);
                    default: d = f_pd(OPS_AZ, OPS_C, 1'b0, 1'b1, 2'd2);
                endcase
            end
            REQ_ROTZ: begin
                case (n)
                    3'd0:    d = f_pd(OPS_AX, OPS_C, 1'b0, 1'b0, 2'd0);
                    3'd1:    d = f_pd(OPS_AY, OPS_S, 1'b1, 1'b1, 2'd0);
                    3'd2:    d = f_pd(OPS_AX, OPS_S, 1'b0, 1'b0, 2'd1);
                    default: d = f_pd(OPS_AY, OPS_C, 1'b0, 1'b1, 2'd1);
                endcase
            end
            default: d = f_pd(OPS_AX, OPS_AX, 1'b0, 1'b0, 2'd0);
        endcase
        return d;
    endfunction

    function automatic logic [2:0] f_nprod(input t_req req);
        unique case (req)
            REQ_CROSS:                    return 3'd6;
            REQ_ROTX, REQ_ROTY, REQ_ROTZ: return 3'd4;
            REQ_SCALE, REQ_DOT,
            REQ_LEN, REQ_NORM:            return 3'd3;
            default:                      return 3'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [67:0] v);
        if (v > SAT_HI) return SAT_HI[31:0];
        if (v < SAT_LO) return SAT_LO[31:0];
        return v[31:0];
    endfunction

    // round to nearest, ties up, then saturate
    function automatic logic signed [31:0] f_round(input logic signed [67:0] v,
                                                   input logic rot);
        logic signed [67:0] t;
        if (rot) t = (v + HALF30) >>> 30;
        else     t = (v + HALF16) >>> 16;
        return f_sat(t);
    endfunction

    // state and datapath registers
    t_be_state          r_state, n_state;
    logic [5:0]         r_cnt, n_cnt;
    t_q_beat            r_item, n_item;
    logic signed [31:0] r_res [4];
    logic signed [31:0] n_res [4];
    logic               r_zl, n_zl;
    logic signed [67:0] r_acc, n_acc;
    logic signed [67:0] r_prod, n_prod;
    logic               r_pv, n_pv;
    t_pdesc             r_pdesc, n_pdesc;
    logic [63:0]        r_op, n_op;
    logic [63:0]        r_root, n_root;
    logic [63:0]        r_bit, n_bit;
    logic [32:0]        r_len, n_len;
    logic [1:0]         r_comp, n_comp;
    logic [47:0]        r_dnum, n_dnum;
    logic [32:0]        r_rem, n_rem;
    logic [47:0]        r_quo, n_quo;
    logic               r_dneg, n_dneg;
    logic [31:0]        r_ang, n_ang;
    logic               r_flip, n_flip;
    logic signed [23:0] r_a24, n_a24;
    logic signed [42:0] r_ph, n_ph;
    logic signed [42:0] r_pl, n_pl;
    logic signed [33:0] r_cx, n_cx;
    logic signed [33:0] r_cy, n_cy;
    logic signed [33:0] r_cz, n_cz;

    // combinational helpers
    t_req               w_req;
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic signed [31:0] w_k;
    logic [2:0]         w_nprod;
    t_pdesc             w_desc;
    logic signed [33:0] w_opa, w_opb;
    logic signed [67:0] w_mul;
    logic signed [67:0] w_acc_next;
    logic               w_rot;

    assign w_req   = t_req'(r_item.req.req_type);
    assign w_a[0]  = r_item.req.ax;
    assign w_a[1]  = r_item.req.ay;
    assign w_a[2]  = r_item.req.az;
    assign w_b[0]  = r_item.req.bx;
    assign w_b[1]  = r_item.req.by_comp;
    assign w_b[2]  = r_item.req.bz;
    assign w_k     = r_item.req.scalar_in;
    assign w_nprod = f_nprod(w_req);
    assign w_desc  = f_pdesc(w_req, r_cnt[2:0]);
    assign w_rot   = (r_item.cls == CL_ROT);

    // multiplier operand muxes
    always_comb begin
        case (w_desc.sa)
            OPS_AY:  w_opa = 34'(w_a[1]);
            OPS_AZ:  w_opa = 34'(w_a[2]);
            default: w_opa = 34'(w_a[0]);
        endcase
        case (w_desc.sb)
            OPS_AX:  w_opb = 34'(w_a[0]);
            OPS_AY:  w_opb = 34'(w_a[1]);
            OPS_AZ:  w_opb = 34'(w_a[2]);
            OPS_BX:  w_opb = 34'(w_b[0]);
            OPS_BY:  w_opb = 34'(w_b[1]);
            OPS_BZ:  w_opb = 34'(w_b[2]);
            OPS_K:   w_opb = 34'(w_k);
            OPS_C:   w_opb = r_cx;
            default: w_opb = r_cy;
        endcase
    end

    assign w_mul = w_opa * w_opb;

    // accumulator input for the product that lands this cycle
    always_comb begin
        w_acc_next = r_acc;
        if (r_pv) begin
            w_acc_next = r_pdesc.neg ? (r_acc - r_prod) : (r_acc + r_prod);
        end
    end

    // sequencer: next state and datapath
    always_comb begin
        logic [31:0]        v_thr;
        logic signed [32:0] v_m;
        logic signed [63:0] v_full;
        logic signed [33:0] v_xs, v_ys, v_xn, v_yn;
        logic [63:0]        v_t;
        logic [33:0]        v_rem2;
        logic               v_qb;
        logic [47:0]        v_q;
        logic [31:0]        v_abs;
        logic [32:0]        v_len;

        n_state = r_state;  n_cnt  = r_cnt;   n_item = r_item;  n_res  = r_res;
        n_zl    = r_zl;     n_acc  = r_acc;   n_prod = r_prod;  n_pv   = 1'b0;
        n_pdesc = r_pdesc;  n_op   = r_op;    n_root = r_root;  n_bit  = r_bit;
        n_len   = r_len;    n_comp = r_comp;  n_dnum = r_dnum;  n_rem  = r_rem;
        n_quo   = r_quo;    n_dneg = r_dneg;  n_ang  = r_ang;   n_flip = r_flip;
        n_a24   = r_a24;    n_ph   = r_ph;    n_pl   = r_pl;
        n_cx    = r_cx;     n_cy   = r_cy;    n_cz   = r_cz;
        o_pop   = 1'b0;
        v_thr = '0; v_m = '0; v_full = '0; v_xs = '0; v_ys = '0; v_xn = '0; v_yn = '0;
        v_t = '0; v_rem2 = '0; v_qb = 1'b0; v_q = '0; v_abs = '0; v_len = '0;

        unique case (r_state)
            // take the next command (also right after a result beat)
            BE_IDLE, BE_OUT: begin
                n_state = BE_IDLE;
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_head.item;
                    n_state = BE_EXEC;
                end
            end

            // dispatch by class
            BE_EXEC: begin
                for (int i = 0; i < 4; i++) n_res[i] = '0;
                n_zl  = 1'b0;
                n_acc = '0;
                n_cnt = '0;
                case (r_item.cls)
                    CL_LIN: begin
                        for (int i = 0; i < 3; i++) begin
                            case (w_req)
                                REQ_ADD: n_res[i] = f_sat(68'(w_a[i]) + 68'(w_b[i]));
                                REQ_SUB: n_res[i] = f_sat(68'(w_a[i]) - 68'(w_b[i]));
                                default: n_res[i] = f_sat(-68'(w_a[i]));
                            endcase
                        end
                        n_state = BE_OUT;
                    end
                    CL_MUL, CL_SQRT: n_state = BE_MUL;
                    CL_ROT: begin
                        case (w_req)
                            REQ_ROTX: n_res[0] = w_a[0];
                            REQ_ROTY: n_res[1] = w_a[1];
                            default:  n_res[2] = w_a[2];
                        endcase
                        n_ang   = w_k[31] ? (~w_k + 32'd1) : w_k;
                        n_state = BE_RED;
                    end
                    default: n_state = BE_OUT;
                endcase
            end

            // products: issue one per cycle, accumulate in the cycle after
            BE_MUL: begin
                if (r_cnt < {3'b000, w_nprod}) begin
                    n_prod  = w_mul;
                    n_pv    = 1'b1;
                    n_pdesc = w_desc;
                end
                n_acc = w_acc_next;
                if (r_pv && r_pdesc.last) begin
                    n_res[r_pdesc.dst] = f_round(w_acc_next, w_rot);
                    n_acc = '0;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == {3'b000, w_nprod}) begin
                    n_cnt = '0;
                    if (r_item.cls == CL_SQRT) begin
                        n_op    = w_acc_next[63:0];
                        n_root  = '0;
                        n_bit   = 64'd1 << 62;
                        n_state = BE_SQRT;
                    end else begin
                        n_state = BE_OUT;
                    end
                end
            end

            // one result bit of the square root per cycle
            BE_SQRT: begin
                v_t = r_root + r_bit;
                if (r_op >= v_t) begin
                    n_op   = r_op - v_t;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_state = BE_SQFIN;
                end
            end

            // round the root, then length out or normalize
            BE_SQFIN: begin
                v_len = (r_op > r_root) ? (33'(r_root) + 33'd1) : 33'(r_root);
                if (w_req == REQ_LEN) begin
                    n_res[3] = f_sat(68'(v_len));
                    n_state  = BE_OUT;
                end else if (v_len == '0) begin
                    // zero vector: pass a through and flag it
                    for (int i = 0; i < 3; i++) n_res[i] = w_a[i];
                    n_zl    = 1'b1;
                    n_state = BE_OUT;
                end else begin
                    n_len   = v_len;
                    n_comp  = '0;
                    n_state = BE_DSET;
                end
            end

            // dividend |x|*2^16 + len/2 for one component
            BE_DSET: begin
                v_abs   = w_a[r_comp][31] ? (~w_a[r_comp] + 32'd1) : w_a[r_comp];
                n_dneg  = w_a[r_comp][31];
                n_dnum  = {v_abs, 16'd0} + 48'(r_len >> 1);
                n_rem   = '0;
                n_quo   = '0;
                n_cnt   = '0;
                n_state = BE_DIV;
            end

            // restoring divide, one quotient bit per cycle
            BE_DIV: begin
                v_rem2 = {r_rem, r_dnum[47]};
                v_qb   = (v_rem2 >= {1'b0, r_len});
                n_rem  = v_qb ? 33'(v_rem2 - {1'b0, r_len}) : v_rem2[32:0];
                n_dnum = r_dnum << 1;
                v_q    = {r_quo[46:0], v_qb};
                n_quo  = v_q;
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    n_res[r_comp] = r_dneg ? f_sat(-68'(v_q)) : f_sat(68'(v_q));
                    if (r_comp == 2'd2) begin
                        n_state = BE_OUT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = BE_DSET;
                    end
                end
            end

            // |angle| mod 360 by compare/subtract, then fold to [-90,90]
            BE_RED: begin
                if (r_cnt < 6'd7) begin
                    v_thr = DEG360 << (3'd6 - r_cnt[2:0]);
                    if (r_ang >= v_thr) begin
                        n_ang = r_ang - v_thr;
                    end
                    n_cnt = r_cnt + 6'd1;
                end else begin
                    v_m = w_k[31] ? -$signed({1'b0, r_ang}) : $signed({1'b0, r_ang});
                    if (v_m < 0) v_m = v_m + DEG360_S;
                    if (v_m > DEG180_S) v_m = v_m - DEG360_S;
                    n_flip = 1'b0;
                    if (v_m > DEG90_S) begin
                        v_m    = v_m - DEG180_S;
                        n_flip = 1'b1;
                    end else if (v_m < -DEG90_S) begin
                        v_m    = v_m + DEG180_S;
                        n_flip = 1'b1;
                    end
                    n_a24   = v_m[23:0];
                    n_state = BE_RAD0;
                end
            end

            // degrees to radians: two partial products
            BE_RAD0: begin
                n_ph    = r_a24 * $signed({1'b0, RAD_HI});
                n_pl    = r_a24 * $signed({1'b0, RAD_LO});
                n_state = BE_RAD1;
            end

            BE_RAD1: begin
                v_full  = (64'(r_ph) <<< RAD_SPLIT) + 64'(r_pl);
                n_cz    = 34'(v_full >>> 26);
                n_cx    = CORDIC_GAIN;
                n_cy    = '0;
                n_cnt   = '0;
                n_state = BE_CORD;
            end

            // one CORDIC rotation per cycle
            BE_CORD: begin
                v_xs = r_cx >>> r_cnt[4:0];
                v_ys = r_cy >>> r_cnt[4:0];
                if (!r_cz[33]) begin
                    v_xn = r_cx - v_ys;
                    v_yn = r_cy + v_xs;
                    n_cz = r_cz - $signed({2'b00, ATAN_TAB[r_cnt[4:0]]});
                end else begin
                    v_xn = r_cx + v_ys;
                    v_yn = r_cy - v_xs;
                    n_cz = r_cz + $signed({2'b00, ATAN_TAB[r_cnt[4:0]]});
                end
                n_cx  = v_xn;
                n_cy  = v_yn;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                    n_cx    = r_flip ? -v_xn : v_xn;
                    n_cy    = r_flip ? -v_yn : v_yn;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = BE_MUL;
                end
            end

            default: n_state = BE_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;  r_res  <= n_res;   r_zl   <= n_zl;    r_acc  <= n_acc;
        r_prod  <= n_prod;  r_pdesc <= n_pdesc; r_op  <= n_op;    r_root <= n_root;
        r_bit   <= n_bit;   r_len  <= n_len;   r_comp <= n_comp;  r_dnum <= n_dnum;
        r_rem   <= n_rem;   r_quo  <= n_quo;   r_dneg <= n_dneg;  r_ang  <= n_ang;
        r_flip  <= n_flip;  r_a24  <= n_a24;   r_ph   <= n_ph;    r_pl   <= n_pl;
        r_cx    <= n_cx;    r_cy   <= n_cy;    r_cz   <= n_cz;
    end

    // result beat
    assign o_valid          = (r_state == BE_OUT);
    assign o_res.rx         = r_res[0];
    assign o_res.ry         = r_res[1];
    assign o_res.rz         = r_res[2];
    assign o_res.scalar_out = r_res[3];
    assign o_res.zero_length = r_zl;

    // a result strobe lasts exactly one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // zero length flag only comes from the square root path
    a_zl_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.zero_length) |-> (r_item.cls == CL_SQRT))
        else $error("zero length flag on wrong operation");

endmodule

// ===== rtl/vec3_operation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_operation_unit
// Q16.16 3D vector unit: add, sub, negate, scale, dot, cross, length,
// normalize and rotation about x, y or z.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a beat on i_req is taken at a clock edge with start
//    high and busy low. busy rises only when the 4-deep command queue is full.
//  - Result channel: o_valid pulses for one cycle with the beat on o_res.
//    The receiver cannot stall; results leave in command order.
//  - Back end work per command (set by its single sequencer):
//    add/sub/negate in the dispatch step, scale/dot/cross on the multiplier,
//    length as a sum of squares then a bit-serial root, normalize as the
//    root and then a restoring divide per component, rotate as angle
//    reduction, radians and CORDIC (one CORDIC step per cycle) then products;
//    others go straight out. The queue absorbs commands while the back end works.
//  - Reset (synchronous, active low) empties the queue and idles the
//    sequencer; no result is pending afterwards.
// ----------------------------------------------------------------------------
module vec3_operation_unit #(
    parameter int CORDIC_STEPS = v3ou_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  v3ou_pkg::t_in_beat  i_req,
    output logic                o_valid,
    output v3ou_pkg::t_out_beat o_res
);
    import v3ou_pkg::*;

    t_q_head w_head;
    logic    w_pop;

    // accept and classify
    v3ou_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_req   (i_req),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // execute
    v3ou_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
